[rtl/wsft_pkg.sv]
`timescale 1ns / 1ps

package wsft_pkg;

    localparam int TABLE_ENTRIES  = 32;
    localparam int WEIGHT_BITS    = 16;

    localparam int KEY_W          = 32;
    localparam int WEIGHT_FIELD_W = 16;
    localparam int SCORE_W        = 11;
    localparam int STATUS_W       = 2;
    localparam int CONF_W         = 10;
    localparam int COUNT_FIELD_W  = 6;
    localparam int OPCODE_W       = 3;

    localparam int W_BITS = (WEIGHT_BITS < WEIGHT_FIELD_W) ? WEIGHT_BITS : WEIGHT_FIELD_W;
    localparam int IDX_W  = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
    localparam int CNT_W  = $clog2(TABLE_ENTRIES + 1);
    localparam int PROD_W = W_BITS + SCORE_W;
    localparam int SUM_W  = PROD_W + CNT_W;
    localparam int ABS_W  = W_BITS + CNT_W;
    localparam int DEN_W  = ABS_W + 1;
    localparam int QUOT_W = 10;
    localparam int DIV_W  = ABS_W + QUOT_W + 2;
    localparam int STEP_W = $clog2(QUOT_W);

    localparam int SCORE_MAX = 999;
    localparam int CONF_MAX  = 999;

    localparam logic [OPCODE_W-1:0] OP_ADD    = 3'd0;
    localparam logic [OPCODE_W-1:0] OP_SETW   = 3'd1;
    localparam logic [OPCODE_W-1:0] OP_IGNORE = 3'd2;
    localparam logic [OPCODE_W-1:0] OP_SETSC  = 3'd3;
    localparam logic [OPCODE_W-1:0] OP_CLRSC  = 3'd4;
    localparam logic [OPCODE_W-1:0] OP_CLRALL = 3'd5;
    localparam logic [OPCODE_W-1:0] OP_QUERY  = 3'd6;

    localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
    localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 2'd1;
    localparam logic [STATUS_W-1:0] ST_DUP_KEY   = 2'd2;
    localparam logic [STATUS_W-1:0] ST_FULL      = 2'd3;

endpackage

[rtl/wsft_div.sv]
`timescale 1ns / 1ps

module wsft_div
    import wsft_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic [DIV_W-1:0]  num,
    input  logic [DEN_W-1:0]  den,
    output logic              done,
    output logic [QUOT_W-1:0] quot
);

    logic [DIV_W-1:0]  rem_reg;
    logic [DIV_W-1:0]  dsh_reg;
    logic [QUOT_W-1:0] quot_reg;
    logic [STEP_W-1:0] step_reg;
    logic              run_reg;
    logic              done_reg;
    logic              ge;

    assign ge   = (rem_reg >= dsh_reg);
    assign done = done_reg;
    assign quot = quot_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
            rem_reg  <= '0;
            dsh_reg  <= '0;
            quot_reg <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                rem_reg  <= num;
                dsh_reg  <= DIV_W'(den) << (QUOT_W - 1);
                quot_reg <= '0;
                step_reg <= STEP_W'(QUOT_W - 1);
                run_reg  <= 1'b1;
            end
            else if (run_reg)
            begin
                if (ge)
                begin
                    rem_reg <= rem_reg - dsh_reg;
                end
                quot_reg <= {quot_reg[QUOT_W-2:0], ge};
                dsh_reg  <= dsh_reg >> 1;
                step_reg <= step_reg - 1'b1;
                if (step_reg == '0)
                begin
                    run_reg  <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

endmodule

[rtl/weighted_score_fusion_table.sv]
`timescale 1ns / 1ps

// weighted score fusion table
// input channel: in_valid / in_ready with opcode, name_key, weight, score;
// one transfer is one table operation (add, set weight, ignore, set score,
// clear scores, clear all, query)
// output channel: out_valid / out_ready with status, confidence_value,
// all_scored and entry_count, exactly one result per input transfer
// an operation walks the stored entries once through a single key compare
// and multiply-accumulate path, one entry per cycle, then runs a shared
// restoring divider for the rounded weighted mean
// the time from input transfer to out_valid grows with the number of stored entries and is
// set by the entry walk over the one read port of the entry memories plus 10 divider steps
// in_ready returns with out_valid, so back-to-back operations never overlap
// in_ready is high only while no operation is in progress; a finished
// result sits in the output register, and a new operation is taken while it
// waits; if the receiver still stalls when the next result is ready, that
// result is held until the output register frees up
// reset empties the table (entry count zero) and drops any pending result;
// entry contents need no clearing since only the first count slots are read

module weighted_score_fusion_table
    import wsft_pkg::*;
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  logic [OPCODE_W-1:0]          opcode,
    input  logic [KEY_W-1:0]             name_key,
    input  logic signed [WEIGHT_FIELD_W-1:0] weight,
    input  logic signed [SCORE_W-1:0]    score,
    output logic                         out_valid,
    input  logic                         out_ready,
    output logic [STATUS_W-1:0]          status,
    output logic [CONF_W-1:0]            confidence_value,
    output logic                         all_scored,
    output logic [COUNT_FIELD_W-1:0]     entry_count
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_SWEEP,
        S_DRAIN,
        S_ADD,
        S_DIV_GO,
        S_DIV_WAIT,
        S_FIN
    } state_t;

    state_t state_reg;

    logic [OPCODE_W-1:0]      op_reg;
    logic [KEY_W-1:0]         key_reg;
    logic signed [W_BITS-1:0] w_in_reg;
    logic signed [SCORE_W-1:0] s_in_reg;

    logic [CNT_W-1:0]  count_reg;
    logic [CNT_W-1:0]  rd_idx_reg;
    logic              found_reg;
    logic              all_ok_reg;
    logic              add_done_reg;
    logic [STATUS_W-1:0] st_reg;

    logic              s1_vld_reg;
    logic              s1_inj_reg;
    logic [IDX_W-1:0]  s1_idx_reg;
    logic              s2_vld_reg;
    logic signed [PROD_W-1:0] prod_reg;
    logic [W_BITS-1:0] absw_reg;

    logic signed [SUM_W-1:0] ts_reg;
    logic [ABS_W-1:0]  tw_reg;

    logic              out_valid_reg;
    logic [STATUS_W-1:0] status_reg;
    logic [CONF_W-1:0] conf_reg;
    logic              all_scored_reg;
    logic [CNT_W-1:0]  count_out_reg;

    logic [KEY_W-1:0]          key_mem [TABLE_ENTRIES];
    logic signed [W_BITS-1:0]  wt_mem  [TABLE_ENTRIES];
    logic signed [SCORE_W-1:0] sc_mem  [TABLE_ENTRIES];
    logic [KEY_W-1:0]          key_q;
    logic signed [W_BITS-1:0]  wt_q;
    logic signed [SCORE_W-1:0] sc_q;

    logic in_xfer;
    logic rd_en;
    logic table_full;
    logic add_we;
    logic key_hit;
    logic mod_hit;
    logic signed [SCORE_W-1:0] s_add;
    logic signed [SCORE_W-1:0] s_set;
    logic signed [W_BITS-1:0]  w_raw;
    logic signed [SCORE_W-1:0] s_raw;
    logic signed [W_BITS-1:0]  w_eff;
    logic signed [SCORE_W-1:0] s_eff;
    logic signed [PROD_W-1:0]  prod_c;
    logic [W_BITS-1:0]         absw_c;
    logic                      wt_we;
    logic                      sc_we;
    logic [IDX_W-1:0]          wt_waddr;
    logic [IDX_W-1:0]          sc_waddr;
    logic signed [W_BITS-1:0]  wt_wdata;
    logic signed [SCORE_W-1:0] sc_wdata;

    logic              div_start;
    logic              div_done;
    logic [QUOT_W-1:0] div_quot;
    logic [DIV_W-1:0]  div_num;
    logic [DEN_W-1:0]  div_den;
    logic [CONF_W-1:0] conf_c;

    assign in_ready   = (state_reg == S_IDLE);
    assign in_xfer    = in_valid && in_ready;
    assign rd_en      = (state_reg == S_SWEEP) && (rd_idx_reg < count_reg);
    assign table_full = (count_reg == CNT_W'(TABLE_ENTRIES));
    assign add_we     = (state_reg == S_ADD) && !found_reg && !table_full;

    always_comb
    begin
        if (s_in_reg < -1)
            s_add = -11'sd1;
        else if (s_in_reg > SCORE_MAX)
            s_add = SCORE_W'(SCORE_MAX);
        else
            s_add = s_in_reg;
        if (s_in_reg < 1)
            s_set = 11'sd1;
        else if (s_in_reg > SCORE_MAX)
            s_set = SCORE_W'(SCORE_MAX);
        else
            s_set = s_in_reg;
    end

    // entry evaluation with the pending change folded in
    assign key_hit = s1_vld_reg && !s1_inj_reg && (key_q == key_reg);
    assign mod_hit = key_hit && (op_reg == OP_SETW || op_reg == OP_IGNORE
                                 || op_reg == OP_SETSC);
    assign w_raw   = s1_inj_reg ? w_in_reg : wt_q;
    assign s_raw   = s1_inj_reg ? s_add : sc_q;

    always_comb
    begin
        w_eff = w_raw;
        s_eff = s_raw;
        if (mod_hit && op_reg == OP_SETW)
            w_eff = w_in_reg;
        if (mod_hit && op_reg == OP_IGNORE)
            w_eff = '0;
        if (mod_hit && op_reg == OP_SETSC)
            s_eff = s_set;
        if (!s1_inj_reg && op_reg == OP_CLRSC)
            s_eff = -11'sd1;
        prod_c = '0;
        absw_c = '0;
        if (w_eff != 0 && s_eff > 0)
        begin
            prod_c = PROD_W'(w_eff) * PROD_W'(s_eff);
            absw_c = w_eff[W_BITS-1] ? W_BITS'(-w_eff) : W_BITS'(w_eff);
        end
    end

    assign wt_we    = add_we || (mod_hit && (op_reg == OP_SETW || op_reg == OP_IGNORE));
    assign wt_waddr = add_we ? count_reg[IDX_W-1:0] : s1_idx_reg;
    assign wt_wdata = add_we ? w_in_reg : w_eff;
    assign sc_we    = add_we || (mod_hit && op_reg == OP_SETSC)
                      || (s1_vld_reg && !s1_inj_reg && op_reg == OP_CLRSC);
    assign sc_waddr = add_we ? count_reg[IDX_W-1:0] : s1_idx_reg;
    assign sc_wdata = add_we ? s_add : s_eff;

    always_ff @(posedge clk)
    begin
        if (add_we)
            key_mem[count_reg[IDX_W-1:0]] <= key_reg;
        if (wt_we)
            wt_mem[wt_waddr] <= wt_wdata;
        if (sc_we)
            sc_mem[sc_waddr] <= sc_wdata;
        if (rd_en)
        begin
            key_q <= key_mem[rd_idx_reg[IDX_W-1:0]];
            wt_q  <= wt_mem[rd_idx_reg[IDX_W-1:0]];
            sc_q  <= sc_mem[rd_idx_reg[IDX_W-1:0]];
        end
    end

    assign div_start = (state_reg == S_DIV_GO);
    assign div_num   = (DIV_W'($unsigned(ts_reg)) << 1) + DIV_W'(tw_reg);
    assign div_den   = {tw_reg, 1'b0};

    wsft_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (div_num),
        .den   (div_den),
        .done  (div_done),
        .quot  (div_quot)
    );

    always_comb
    begin
        if (tw_reg == '0)
            conf_c = '0;
        else if (ts_reg <= 0 || div_quot == '0)
            conf_c = CONF_W'(1);
        else if (div_quot > QUOT_W'(CONF_MAX))
            conf_c = CONF_W'(CONF_MAX);
        else
            conf_c = CONF_W'(div_quot);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            op_reg         <= OP_QUERY;
            key_reg        <= '0;
            w_in_reg       <= '0;
            s_in_reg       <= '0;
            count_reg      <= '0;
            rd_idx_reg     <= '0;
            found_reg      <= 1'b0;
            all_ok_reg     <= 1'b1;
            add_done_reg   <= 1'b0;
            st_reg         <= ST_OK;
            s1_vld_reg     <= 1'b0;
            s1_inj_reg     <= 1'b0;
            s1_idx_reg     <= '0;
            s2_vld_reg     <= 1'b0;
            prod_reg       <= '0;
            absw_reg       <= '0;
            ts_reg         <= '0;
            tw_reg         <= '0;
            out_valid_reg  <= 1'b0;
            status_reg     <= ST_OK;
            conf_reg       <= '0;
            all_scored_reg <= 1'b0;
            count_out_reg  <= '0;
        end
        else
        begin
            // entry pipeline: read, evaluate, accumulate
            s1_vld_reg <= rd_en || add_we;
            s1_inj_reg <= add_we;
            s1_idx_reg <= rd_idx_reg[IDX_W-1:0];
            s2_vld_reg <= s1_vld_reg;
            prod_reg   <= prod_c;
            absw_reg   <= absw_c;
            if (s2_vld_reg)
            begin
                ts_reg <= ts_reg + SUM_W'(prod_reg);
                tw_reg <= tw_reg + ABS_W'(absw_reg);
            end
            if (key_hit)
                found_reg <= 1'b1;
            if (s1_vld_reg && w_eff != 0 && s_eff < 0)
                all_ok_reg <= 1'b0;

            if (out_valid_reg && out_ready && state_reg != S_FIN)
                out_valid_reg <= 1'b0;

            unique case (state_reg)
                S_IDLE:
                begin
                    if (in_xfer)
                    begin
                        op_reg       <= opcode;
                        key_reg      <= name_key;
                        w_in_reg     <= weight[W_BITS-1:0];
                        s_in_reg     <= score;
                        ts_reg       <= '0;
                        tw_reg       <= '0;
                        all_ok_reg   <= 1'b1;
                        found_reg    <= 1'b0;
                        add_done_reg <= 1'b0;
                        st_reg       <= ST_OK;
                        rd_idx_reg   <= '0;
                        if (opcode == OP_CLRALL)
                            count_reg <= '0;
                        state_reg <= S_SWEEP;
                    end
                end
                S_SWEEP:
                begin
                    if (rd_en)
                        rd_idx_reg <= rd_idx_reg + 1'b1;
                    else
                        state_reg <= S_DRAIN;
                end
                S_DRAIN:
                begin
                    if (!s1_vld_reg && !s2_vld_reg)
                    begin
                        if (op_reg == OP_ADD && !add_done_reg)
                        begin
                            state_reg <= S_ADD;
                        end
                        else
                        begin
                            if ((op_reg == OP_SETW || op_reg == OP_IGNORE
                                 || op_reg == OP_SETSC) && !found_reg)
                                st_reg <= ST_NOT_FOUND;
                            state_reg <= S_DIV_GO;
                        end
                    end
                end
                S_ADD:
                begin
                    add_done_reg <= 1'b1;
                    if (found_reg)
                        st_reg <= ST_DUP_KEY;
                    else if (table_full)
                        st_reg <= ST_FULL;
                    else
                        count_reg <= count_reg + 1'b1;
                    state_reg <= S_DRAIN;
                end
                S_DIV_GO:
                begin
                    state_reg <= S_DIV_WAIT;
                end
                S_DIV_WAIT:
                begin
                    if (div_done)
                        state_reg <= S_FIN;
                end
                S_FIN:
                begin
                    if (!out_valid_reg || out_ready)
                    begin
                        out_valid_reg  <= 1'b1;
                        status_reg     <= st_reg;
                        conf_reg       <= conf_c;
                        all_scored_reg <= all_ok_reg;
                        count_out_reg  <= count_reg;
                        state_reg      <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign out_valid        = out_valid_reg;
    assign status           = status_reg;
    assign confidence_value = conf_reg;
    assign all_scored       = all_scored_reg;
    assign entry_count      = COUNT_FIELD_W'(count_out_reg);

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(TABLE_ENTRIES))
        else $error("entry count beyond table size");

    a_busy_after_xfer: assert property (@(posedge clk) disable iff (!rst_n)
        in_xfer |=> !in_ready)
        else $error("input taken while an operation is in progress");

    a_div_done_wait: assert property (@(posedge clk) disable iff (!rst_n)
        div_done |-> (state_reg == S_DIV_WAIT))
        else $error("divider finished outside its wait state");

    a_conf_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (conf_reg <= CONF_W'(CONF_MAX)))
        else $error("confidence out of range");

    a_no_write_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_IDLE) |-> (!wt_we && !sc_we && !add_we))
        else $error("entry memory written while idle");

endmodule

[dv/tb_weighted_score_fusion_table.sv]
`timescale 1ns / 1ps

module tb_weighted_score_fusion_table;
    import wsft_pkg::*;

    localparam logic [OPCODE_W-1:0] OP_SPARE = 3'd7;
    localparam int RANDOM_ITEMS   = 640;
    localparam int WATCHDOG_LIMIT = 5000;
    localparam int SETTLE_CYCLES  = 80;
    localparam int REPORT_LIMIT   = 10;

    typedef struct {
        logic [STATUS_W-1:0]      status;
        logic [CONF_W-1:0]        conf;
        logic                     all_scored;
        logic [COUNT_FIELD_W-1:0] count;
    } fusion_result_t;

    class fusion_scoreboard;
        logic [KEY_W-1:0] slot_key [TABLE_ENTRIES];
        int               slot_weight [TABLE_ENTRIES];
        int               slot_score [TABLE_ENTRIES];
        int               used;
        fusion_result_t   expected_q [$];
        int               mismatches;

        function new();
            used = 0;
            mismatches = 0;
        endfunction

        function int find_slot(logic [KEY_W-1:0] key);
            for (int i = 0; i < used; i++)
                if (slot_key[i] == key)
                    return i;
            return -1;
        endfunction

        function int clamp(int v, int lo, int hi);
            if (v < lo)
                return lo;
            if (v > hi)
                return hi;
            return v;
        endfunction

        function logic [CONF_W-1:0] weighted_mean();
            longint num;
            longint den;
            longint q;
            num = 0;
            den = 0;
            for (int i = 0; i < used; i++)
                if (slot_weight[i] != 0 && slot_score[i] > 0)
                begin
                    num += longint'(slot_weight[i]) * longint'(slot_score[i]);
                    den += longint'((slot_weight[i] < 0) ? -slot_weight[i]
                                                         : slot_weight[i]);
                end
            if (den == 0)
                return '0;
            if (num <= 0)
                return CONF_W'(1);
            q = (2 * num + den) / (2 * den);
            if (q < 1)
                q = 1;
            if (q > CONF_MAX)
                q = CONF_MAX;
            return q[CONF_W-1:0];
        endfunction

        function logic weighted_all_scored();
            for (int i = 0; i < used; i++)
                if (slot_weight[i] != 0 && slot_score[i] < 0)
                    return 1'b0;
            return 1'b1;
        endfunction

        function void note_input(logic [OPCODE_W-1:0] op, logic [KEY_W-1:0] key,
                                 logic signed [WEIGHT_FIELD_W-1:0] w,
                                 logic signed [SCORE_W-1:0] s);
            fusion_result_t r;
            int idx;
            int wv;
            int sv;
            wv = int'($signed(w[W_BITS-1:0]));
            sv = int'(s);
            r.status = ST_OK;
            idx = find_slot(key);
            case (op)
                OP_ADD:
                begin
                    if (idx >= 0)
                        r.status = ST_DUP_KEY;
                    else if (used >= TABLE_ENTRIES)
                        r.status = ST_FULL;
                    else
                    begin
                        slot_key[used] = key;
                        slot_weight[used] = wv;
                        slot_score[used] = clamp(sv, -1, SCORE_MAX);
                        used++;
                    end
                end
                OP_SETW, OP_IGNORE, OP_SETSC:
                begin
                    if (idx < 0)
                        r.status = ST_NOT_FOUND;
                    else if (op == OP_SETW)
                        slot_weight[idx] = wv;
                    else if (op == OP_IGNORE)
                        slot_weight[idx] = 0;
                    else
                        slot_score[idx] = clamp(sv, 1, SCORE_MAX);
                end
                OP_CLRSC:
                    for (int i = 0; i < used; i++)
                        slot_score[i] = -1;
                OP_CLRALL:
                    used = 0;
                default:
                    ;
            endcase
            r.conf = weighted_mean();
            r.all_scored = weighted_all_scored();
            r.count = used[COUNT_FIELD_W-1:0];
            expected_q.push_back(r);
        endfunction

        function void check_result(logic [STATUS_W-1:0] st, logic [CONF_W-1:0] conf,
                                   logic all_sc, logic [COUNT_FIELD_W-1:0] cnt);
            fusion_result_t e;
            if (expected_q.size() == 0)
            begin
                if (mismatches < REPORT_LIMIT)
                    $display("unexpected result: status %0d conf %0d all_scored %0d count %0d",
                             st, conf, all_sc, cnt);
                mismatches++;
                return;
            end
            e = expected_q.pop_front();
            if (e.status !== st || e.conf !== conf || e.all_scored !== all_sc
                || e.count !== cnt)
            begin
                if (mismatches < REPORT_LIMIT)
                begin
                    $display("mismatch at %0t: expected status %0d conf %0d all_sc %0d count %0d",
                             $time, e.status, e.conf, e.all_scored, e.count);
                    $display("    got status %0d conf %0d all_sc %0d count %0d",
                             st, conf, all_sc, cnt);
                end
                mismatches++;
            end
        endfunction

        function int pending();
            return expected_q.size();
        endfunction

        function logic [KEY_W-1:0] held_key();
            if (used == 0)
                return $urandom;
            return slot_key[$urandom_range(0, used - 1)];
        endfunction
    endclass

    logic                             clk;
    logic                             rst_n;
    logic                             in_valid;
    logic                             in_ready;
    logic [OPCODE_W-1:0]              opcode;
    logic [KEY_W-1:0]                 name_key;
    logic signed [WEIGHT_FIELD_W-1:0] weight;
    logic signed [SCORE_W-1:0]        score;
    logic                             out_valid;
    logic                             out_ready;
    logic [STATUS_W-1:0]              status;
    logic [CONF_W-1:0]                confidence_value;
    logic                             all_scored;
    logic [COUNT_FIELD_W-1:0]         entry_count;

    fusion_scoreboard sb = new();
    int  items_sent;
    int  idle_cycles;
    int  stall_left;
    bit  quiet;
    bit  pressured;

    weighted_score_fusion_table i_dut (
        .clk              (clk),
        .rst_n            (rst_n),
        .in_valid         (in_valid),
        .in_ready         (in_ready),
        .opcode           (opcode),
        .name_key         (name_key),
        .weight           (weight),
        .score            (score),
        .out_valid        (out_valid),
        .out_ready        (out_ready),
        .status           (status),
        .confidence_value (confidence_value),
        .all_scored       (all_scored),
        .entry_count      (entry_count)
    );

    always #5 clk = ~clk;

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 65)
            return 0;
        if (r < 93)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    function automatic logic signed [WEIGHT_FIELD_W-1:0] pick_weight();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50)
            return WEIGHT_FIELD_W'($urandom_range(0, 200) - 100);
        if (r < 70)
            return WEIGHT_FIELD_W'($urandom_range(1, 20));
        if (r < 80)
            return '0;
        if (r < 95)
            return WEIGHT_FIELD_W'($urandom);
        return ($urandom_range(0, 1) == 1) ? 16'h7FFF : 16'h8000;
    endfunction

    function automatic logic signed [SCORE_W-1:0] pick_score();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70)
            return SCORE_W'($urandom_range(1, SCORE_MAX));
        if (r < 78)
            return -11'sd1;
        if (r < 85)
            return '0;
        return SCORE_W'($urandom_range(0, 2047));
    endfunction

    function automatic logic [KEY_W-1:0] pick_key();
        if ($urandom_range(0, 99) < 80)
            return sb.held_key();
        return $urandom;
    endfunction

    // output side stalls, short mostly, a few long
    always @(posedge clk)
    begin
        if (stall_left > 0)
        begin
            out_ready <= 1'b0;
            stall_left--;
        end
        else if (!quiet && $urandom_range(0, 99) < 30)
        begin
            stall_left = ($urandom_range(0, 99) < 90) ? $urandom_range(0, 2)
                                                      : $urandom_range(15, 60);
            out_ready <= 1'b0;
        end
        else
            out_ready <= 1'b1;
    end

    // transfer monitor and watchdog
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (in_valid && in_ready)
                sb.note_input(opcode, name_key, weight, score);
            if (out_valid && out_ready)
                sb.check_result(status, confidence_value, all_scored, entry_count);
            if ((in_valid && in_ready) || (out_valid && out_ready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= WATCHDOG_LIMIT)
            begin
                $display("Test completed with failures");
                $finish;
            end
        end
    end

    task automatic send_op(logic [OPCODE_W-1:0] op, logic [KEY_W-1:0] key,
                           logic signed [WEIGHT_FIELD_W-1:0] w,
                           logic signed [SCORE_W-1:0] s);
        int gap;
        gap = quiet ? 0 : pick_gap();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        opcode   <= op;
        name_key <= key;
        weight   <= w;
        score    <= s;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        items_sent++;
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (sb.pending() != 0)
            @(posedge clk);
    endtask

    task automatic fill_table();
        send_op(OP_CLRALL, $urandom, pick_weight(), pick_score());
        for (int i = 0; i <= TABLE_ENTRIES; i++)
            send_op(OP_ADD, $urandom, pick_weight(), pick_score());
        send_op(OP_ADD, sb.held_key(), pick_weight(), pick_score());
    endtask

    task automatic run_directed();
        send_op(OP_QUERY, 32'h0, 16'sd0, 11'sd0);
        send_op(OP_SPARE, 32'hFFFF_FFFF, 16'sd0, 11'sd0);
        send_op(OP_SETW, 32'h1, 16'sd4, 11'sd0);
        send_op(OP_ADD, 32'h0, 16'h7FFF, 11'sd999);
        send_op(OP_ADD, 32'hFFFF_FFFF, 16'h8000, -11'sd1);
        send_op(OP_QUERY, 32'h0, 16'sd0, 11'sd0);
        send_op(OP_ADD, 32'h0, 16'sd1, 11'sd5);
        send_op(OP_ADD, 32'h5, -16'sd100, 11'h3FF);
        send_op(OP_ADD, 32'h6, 16'sd3, 11'h400);
        send_op(OP_SETSC, 32'hFFFF_FFFF, 16'sd0, 11'h400);
        send_op(OP_SETSC, 32'h6, 16'sd0, 11'sd0);
        send_op(OP_SETSC, 32'h5, 16'sd0, 11'h3FF);
        send_op(OP_SETW, 32'h5, 16'sd0, 11'sd0);
        send_op(OP_IGNORE, 32'h0, 16'sd0, 11'sd0);
        send_op(OP_SETSC, 32'h4D, 16'sd0, 11'sd7);
        send_op(OP_IGNORE, 32'h4E, 16'sd0, 11'sd0);
        send_op(OP_CLRSC, 32'h0, 16'sd0, 11'sd0);
        drain();
        send_op(OP_QUERY, 32'h0, 16'sd0, 11'sd0);
        send_op(OP_CLRALL, 32'h0, 16'sd0, 11'sd0);
        // negative weighted sum clamps to one
        send_op(OP_ADD, 32'h1, -16'sd5, 11'sd10);
        send_op(OP_ADD, 32'h2, 16'sd1, 11'sd0);
        send_op(OP_ADD, 32'h3, 16'sd0, -11'sd1);
        send_op(OP_SETW, 32'h3, 16'sd7, 11'sd0);
        send_op(OP_ADD, 32'h4, 16'sd6, 11'sd1);
    endtask

    initial
    begin
        clk = 1'b0;
        rst_n = 1'b0;
        in_valid = 1'b0;
        out_ready = 1'b0;
        opcode = '0;
        name_key = '0;
        weight = '0;
        score = '0;
        items_sent = 0;
        idle_cycles = 0;
        stall_left = 0;
        quiet = 1'b0;
        pressured = 1'b0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        run_directed();
        fill_table();
        items_sent = 0;
        while (items_sent < RANDOM_ITEMS)
        begin
            int kind;
            int n;
            kind = $urandom_range(0, 99);
            quiet = (items_sent >= 400 && items_sent < 480);
            if (!pressured && items_sent >= RANDOM_ITEMS / 2)
            begin
                drain();
                pressured = 1'b1;
            end
            if (kind < 30)
            begin
                n = $urandom_range(1, 8);
                repeat (n)
                    send_op(OP_ADD, ($urandom_range(0, 99) < 70) ? $urandom : sb.held_key(),
                            pick_weight(), pick_score());
            end
            else if (kind < 65)
            begin
                n = $urandom_range(1, 6);
                repeat (n)
                begin
                    case ($urandom_range(0, 2))
                        0: send_op(OP_SETW, pick_key(), pick_weight(), pick_score());
                        1: send_op(OP_IGNORE, pick_key(), pick_weight(), pick_score());
                        default: send_op(OP_SETSC, pick_key(), pick_weight(), pick_score());
                    endcase
                end
            end
            else if (kind < 75)
                send_op(($urandom_range(0, 1) == 1) ? OP_QUERY : OP_SPARE, $urandom,
                        pick_weight(), pick_score());
            else if (kind < 80)
                send_op(OP_CLRSC, pick_key(), pick_weight(), pick_score());
            else if (kind < 84)
                send_op(OP_CLRALL, pick_key(), pick_weight(), pick_score());
            else if (kind < 88)
                fill_table();
            else
                send_op(OPCODE_W'($urandom_range(0, 7)), pick_key(),
                        WEIGHT_FIELD_W'($urandom), SCORE_W'($urandom_range(0, 2047)));
        end
        quiet = 1'b0;

        drain();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (sb.mismatches == 0 && sb.pending() == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
